FILE: design/fgcm_pkg.sv
// Shared constants, codes, controller states and command/status types
// for the feature gallery cosine matcher. No dependencies.
package fgcm_pkg;

	// Sizes
	localparam int FEAT_MAX  = 1024;
	localparam int ENTRY_MAX = 64;
	localparam int ELEM_W    = 16;
	localparam int IDX_W     = $clog2(FEAT_MAX);
	localparam int POS_W     = IDX_W + 1;
	localparam int SLOT_W    = $clog2(ENTRY_MAX);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int GAL_AW    = SLOT_W + IDX_W;
	localparam int GAL_DEPTH = ENTRY_MAX * FEAT_MAX;

	// Register port
	localparam int FLEN_W    = 11;
	localparam int LIMIT_W   = 7;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam logic [FLEN_W-1:0]  FLEN_RESET  = 11'd1024;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [FLEN_W-1:0]  FLEN_MAX_V  = 11'd1024;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX_V = 7'd64;

	// Arithmetic widths
	localparam int SQ_W     = 2 * ELEM_W;
	localparam int NORM_W   = 42;
	localparam int ROOT_W   = 21;
	localparam int DOT_W    = 42;
	localparam int MAG_W    = 41;
	localparam int FRAC_W   = 15;
	localparam int NUM_W    = MAG_W + FRAC_W;
	localparam int QUO_W    = 22;
	localparam int DSH_W    = NORM_W + QUO_W;
	localparam int DCNT_W   = 5;
	localparam int SSUM_W   = 23;
	localparam int SIM_W    = 16;
	localparam int MAXS_W   = 15;

	// Item and result codes
	localparam logic [1:0] FUNC_STORE = 2'd0;
	localparam logic [1:0] FUNC_QUERY = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLEN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PAD,
		ST_STORE_FIN,
		ST_Q_START,
		ST_Q_ROOT,
		ST_Q_CHECK,
		ST_Q_ENTRY,
		ST_Q_NORM,
		ST_Q_MAC,
		ST_Q_MUL,
		ST_Q_DIV,
		ST_Q_DIVWAIT,
		ST_Q_SIM,
		ST_AVG,
		ST_AVGWAIT,
		ST_AVGFIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic pad;
		logic store_fin;
		logic q_start;
		logic rq_latch;
		logic norm_rd;
		logic entry_start;
		logic mul;
		logic div_cos;
		logic sim;
		logic avg_start;
		logic avg_fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic pad_done;
		logic close_store;
		logic sqrt_busy;
		logic mac_busy;
		logic div_busy;
		logic den_zero;
		logic entries_left;
		logic count_zero;
		logic out_free;
	} sts_t;

endpackage

FILE: design/fgcm_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on fgcm_pkg.
module fgcm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fgcm_pkg::NORM_W-1:0]   radicand,
	output logic                          busy,
	output logic [fgcm_pkg::ROOT_W-1:0]   root
);

	localparam logic [fgcm_pkg::NORM_W-1:0] TOP_BIT =
		{{(fgcm_pkg::NORM_W-1){1'b0}}, 1'b1} << (2 * (fgcm_pkg::ROOT_W - 1));

	logic [fgcm_pkg::NORM_W-1:0] bit_q;
	logic [fgcm_pkg::NORM_W-1:0] n_q;
	logic [fgcm_pkg::NORM_W-1:0] root_q;
	logic [fgcm_pkg::NORM_W-1:0] trial;

	assign trial = root_q + bit_q;
	assign busy  = (bit_q != '0);
	assign root  = root_q[fgcm_pkg::ROOT_W-1:0];

	// Step bit walks down two places a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= TOP_BIT;
		end else if (busy) begin
			bit_q <= bit_q >> 2;
		end
	end

	// Remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			root_q <= '0;
		end else if (busy) begin
			if (n_q >= trial) begin
				n_q    <= n_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

endmodule

FILE: design/fgcm_div.sv
// Restoring divider, one quotient bit per cycle, with overflow flag
// for quotients beyond the result width. Depends on fgcm_pkg.
module fgcm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fgcm_pkg::NUM_W-1:0]   num,
	input  logic [fgcm_pkg::NORM_W-1:0]  den,
	output logic                         busy,
	output logic [fgcm_pkg::QUO_W-1:0]   quo,
	output logic                         ovf
);

	localparam logic [fgcm_pkg::DCNT_W-1:0] STEPS = 5'd22;

	logic [fgcm_pkg::DCNT_W-1:0] cnt_q;
	logic [fgcm_pkg::NUM_W-1:0]  rem_q;
	logic [fgcm_pkg::DSH_W-1:0]  dsh_q;
	logic [fgcm_pkg::QUO_W-1:0]  quo_q;
	logic                        ovf_q;
	logic [fgcm_pkg::DSH_W-1:0]  rem_ext;
	logic [fgcm_pkg::DSH_W-1:0]  num_ext;
	logic [fgcm_pkg::DSH_W-1:0]  den_top;

	assign rem_ext = {{(fgcm_pkg::DSH_W-fgcm_pkg::NUM_W){1'b0}}, rem_q};
	assign num_ext = {{(fgcm_pkg::DSH_W-fgcm_pkg::NUM_W){1'b0}}, num};
	assign den_top = {den, {fgcm_pkg::QUO_W{1'b0}}};
	assign busy    = (cnt_q != '0);
	assign quo     = quo_q;
	assign ovf     = ovf_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEPS;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den_top >> 1;
			quo_q <= '0;
			ovf_q <= (num_ext >= den_top);
		end else if (busy) begin
			if (rem_ext >= dsh_q) begin
				rem_q <= rem_q - dsh_q[fgcm_pkg::NUM_W-1:0];
				quo_q <= {quo_q[fgcm_pkg::QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[fgcm_pkg::QUO_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

FILE: design/fgcm_ctrl.sv
// Controller state machine: input handshake and sequencing of the
// datapath through store, pad, search and result phases. Depends on fgcm_pkg.
module fgcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        func,
	input  logic              last_element,
	input  fgcm_pkg::sts_t    sts,
	output logic              in_stall,
	output fgcm_pkg::cmd_t    cmd
);

	fgcm_pkg::state_t state_q;
	fgcm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fgcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != fgcm_pkg::ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			fgcm_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (func == fgcm_pkg::FUNC_CLEAR) begin
						state_d = fgcm_pkg::ST_EMIT;
					end else if ((func == fgcm_pkg::FUNC_STORE ||
						func == fgcm_pkg::FUNC_QUERY) && last_element) begin
						state_d = fgcm_pkg::ST_PAD;
					end
				end
			end
			fgcm_pkg::ST_PAD: begin
				if (sts.pad_done) begin
					state_d = sts.close_store ? fgcm_pkg::ST_STORE_FIN
						: fgcm_pkg::ST_Q_START;
				end else begin
					cmd.pad = 1'b1;
				end
			end
			fgcm_pkg::ST_STORE_FIN: begin
				cmd.store_fin = 1'b1;
				state_d = fgcm_pkg::ST_EMIT;
			end
			fgcm_pkg::ST_Q_START: begin
				cmd.q_start = 1'b1;
				state_d = fgcm_pkg::ST_Q_ROOT;
			end
			fgcm_pkg::ST_Q_ROOT: begin
				if (!sts.sqrt_busy) begin
					cmd.rq_latch = 1'b1;
					state_d = fgcm_pkg::ST_Q_CHECK;
				end
			end
			fgcm_pkg::ST_Q_CHECK: begin
				state_d = sts.entries_left ? fgcm_pkg::ST_Q_ENTRY : fgcm_pkg::ST_AVG;
			end
			fgcm_pkg::ST_Q_ENTRY: begin
				cmd.norm_rd = 1'b1;
				state_d = fgcm_pkg::ST_Q_NORM;
			end
			fgcm_pkg::ST_Q_NORM: begin
				cmd.entry_start = 1'b1;
				state_d = fgcm_pkg::ST_Q_MAC;
			end
			fgcm_pkg::ST_Q_MAC: begin
				if (!sts.sqrt_busy && !sts.mac_busy) begin
					state_d = fgcm_pkg::ST_Q_MUL;
				end
			end
			fgcm_pkg::ST_Q_MUL: begin
				cmd.mul = 1'b1;
				state_d = fgcm_pkg::ST_Q_DIV;
			end
			fgcm_pkg::ST_Q_DIV: begin
				if (sts.den_zero) begin
					state_d = fgcm_pkg::ST_Q_SIM;
				end else begin
					cmd.div_cos = 1'b1;
					state_d = fgcm_pkg::ST_Q_DIVWAIT;
				end
			end
			fgcm_pkg::ST_Q_DIVWAIT: begin
				if (!sts.div_busy) begin
					state_d = fgcm_pkg::ST_Q_SIM;
				end
			end
			fgcm_pkg::ST_Q_SIM: begin
				cmd.sim = 1'b1;
				state_d = fgcm_pkg::ST_Q_CHECK;
			end
			fgcm_pkg::ST_AVG: begin
				if (sts.count_zero) begin
					state_d = fgcm_pkg::ST_AVGFIN;
				end else begin
					cmd.avg_start = 1'b1;
					state_d = fgcm_pkg::ST_AVGWAIT;
				end
			end
			fgcm_pkg::ST_AVGWAIT: begin
				if (!sts.div_busy) begin
					state_d = fgcm_pkg::ST_AVGFIN;
				end
			end
			fgcm_pkg::ST_AVGFIN: begin
				cmd.avg_fin = 1'b1;
				state_d = fgcm_pkg::ST_EMIT;
			end
			fgcm_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = fgcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fgcm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/fgcm_datapath.sv
// Datapath: registers, gallery/query/norm memories, dot-product MAC,
// root and divide units, result and output registers.
// Depends on fgcm_pkg, fgcm_sqrt and fgcm_div.
module fgcm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fgcm_pkg::cmd_t                      cmd,
	output fgcm_pkg::sts_t                      sts,
	input  logic                                cfg_write,
	input  logic [fgcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fgcm_pkg::CFG_W-1:0]          cfg_data,
	input  logic [1:0]                          func,
	input  logic signed [fgcm_pkg::ELEM_W-1:0]  element_value,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [1:0]                          result_kind,
	output logic [fgcm_pkg::MAXS_W-1:0]         max_similarity,
	output logic signed [fgcm_pkg::SIM_W-1:0]   avg_similarity,
	output logic [fgcm_pkg::CNT_W-1:0]          entry_count,
	output logic                                gallery_full,
	output logic [fgcm_pkg::SLOT_W-1:0]         written_slot
);

	// Configuration and gallery bookkeeping
	logic [fgcm_pkg::FLEN_W-1:0]  flen_q;
	logic [fgcm_pkg::LIMIT_W-1:0] limit_q;
	logic [fgcm_pkg::SLOT_W-1:0]  replace_q;
	logic [fgcm_pkg::SLOT_W-1:0]  target_q;
	logic [fgcm_pkg::CNT_W-1:0]   count_q;
	logic [fgcm_pkg::POS_W-1:0]   pos_q;
	logic [fgcm_pkg::NORM_W-1:0]  sqsum_q;
	logic [1:0]                   close_func_q;
	logic [fgcm_pkg::CNT_W-1:0]   e_q;

	// MAC pipeline
	logic                               mac_run_q;
	logic [fgcm_pkg::POS_W-1:0]         mac_i_q;
	logic                               rd_v_s1;
	logic                               prod_v_s2;
	logic signed [fgcm_pkg::ELEM_W-1:0] gal_rd_s1;
	logic signed [fgcm_pkg::ELEM_W-1:0] q_rd_s1;
	logic signed [fgcm_pkg::SQ_W-1:0]   prod_s2;
	logic [fgcm_pkg::DOT_W-1:0]         acc_q;

	// Per-entry and query results
	logic [fgcm_pkg::NORM_W-1:0]        norm_rd_q;
	logic [fgcm_pkg::ROOT_W-1:0]        rq_q;
	logic [fgcm_pkg::NORM_W-1:0]        den_q;
	logic                               den_zero_q;
	logic [fgcm_pkg::MAG_W-1:0]         mag_q;
	logic                               neg_q;
	logic [fgcm_pkg::SSUM_W-1:0]        ssum_q;
	logic [fgcm_pkg::MAXS_W-1:0]        max_q;
	logic [1:0]                         res_kind_q;
	logic [fgcm_pkg::MAXS_W-1:0]        res_max_q;
	logic [fgcm_pkg::SIM_W-1:0]         res_avg_q;
	logic [fgcm_pkg::SLOT_W-1:0]        res_slot_q;

	// Output register
	logic                               out_valid_q;
	logic [1:0]                         out_kind_q;
	logic [fgcm_pkg::MAXS_W-1:0]        out_max_q;
	logic [fgcm_pkg::SIM_W-1:0]         out_avg_q;
	logic [fgcm_pkg::CNT_W-1:0]         out_count_q;
	logic                               out_full_q;
	logic [fgcm_pkg::SLOT_W-1:0]        out_slot_q;

	// Memories
	logic signed [fgcm_pkg::ELEM_W-1:0] gal_mem [fgcm_pkg::GAL_DEPTH];
	logic signed [fgcm_pkg::ELEM_W-1:0] q_mem [fgcm_pkg::FEAT_MAX];
	logic [fgcm_pkg::NORM_W-1:0]        norm_mem [fgcm_pkg::ENTRY_MAX];

	// Combinational helpers
	logic                               elem_live;
	logic                               in_range;
	logic [fgcm_pkg::SLOT_W-1:0]        new_slot;
	logic [fgcm_pkg::SLOT_W-1:0]        tslot;
	logic signed [fgcm_pkg::SQ_W-1:0]   elem_sq;
	logic                               gal_we;
	logic                               q_we;
	logic [fgcm_pkg::GAL_AW-1:0]        gal_wa;
	logic signed [fgcm_pkg::ELEM_W-1:0] wr_data;
	logic [fgcm_pkg::GAL_AW-1:0]        gal_ra;
	logic [fgcm_pkg::FLEN_W-1:0]        cfg_flen;
	logic [fgcm_pkg::LIMIT_W-1:0]       cfg_lim;
	logic [fgcm_pkg::LIMIT_W-1:0]       rep_inc;
	logic [fgcm_pkg::DOT_W-1:0]         acc_abs;
	logic [fgcm_pkg::SSUM_W-1:0]        ssum_abs;
	logic                               sqrt_start;
	logic [fgcm_pkg::NORM_W-1:0]        sqrt_rad;
	logic                               sqrt_busy;
	logic [fgcm_pkg::ROOT_W-1:0]        sqrt_root;
	logic                               div_start;
	logic [fgcm_pkg::NUM_W-1:0]         div_num;
	logic [fgcm_pkg::NORM_W-1:0]        div_den;
	logic                               div_busy;
	logic [fgcm_pkg::QUO_W-1:0]         div_quo;
	logic                               div_ovf;
	logic signed [fgcm_pkg::SIM_W-1:0]  sim_val;
	logic [fgcm_pkg::SIM_W-1:0]         avg_val;

	// Clamp register writes to their legal ranges
	always_comb begin
		cfg_flen = cfg_data[fgcm_pkg::FLEN_W-1:0];
		if (cfg_flen == '0) begin
			cfg_flen = 11'd1;
		end else if (cfg_flen > fgcm_pkg::FLEN_MAX_V) begin
			cfg_flen = fgcm_pkg::FLEN_MAX_V;
		end
		cfg_lim = cfg_data[fgcm_pkg::LIMIT_W-1:0];
		if (cfg_lim == '0) begin
			cfg_lim = 7'd1;
		end else if (cfg_lim > fgcm_pkg::LIMIT_MAX_V) begin
			cfg_lim = fgcm_pkg::LIMIT_MAX_V;
		end
	end

	// Element write path, shared by accepted elements and zero padding
	assign elem_live = cmd.take && (func == fgcm_pkg::FUNC_STORE || func == fgcm_pkg::FUNC_QUERY);
	assign in_range  = ({1'b0, pos_q[fgcm_pkg::POS_W-2:0]} == pos_q) ?
		(pos_q < flen_q) : (pos_q < flen_q);
	assign new_slot  = ({1'b0, count_q} < {1'b0, limit_q}) ?
		count_q[fgcm_pkg::SLOT_W-1:0] : replace_q;
	assign tslot     = (pos_q == '0) ? new_slot : target_q;
	assign elem_sq   = element_value * element_value;
	assign gal_we    = in_range && ((elem_live && func == fgcm_pkg::FUNC_STORE) ||
		(cmd.pad && close_func_q == fgcm_pkg::FUNC_STORE));
	assign q_we      = in_range && ((elem_live && func == fgcm_pkg::FUNC_QUERY) ||
		(cmd.pad && close_func_q == fgcm_pkg::FUNC_QUERY));
	assign gal_wa    = {(cmd.take ? tslot : target_q), pos_q[fgcm_pkg::IDX_W-1:0]};
	assign wr_data   = cmd.take ? element_value : '0;
	assign gal_ra    = {e_q[fgcm_pkg::SLOT_W-1:0], mac_i_q[fgcm_pkg::IDX_W-1:0]};
	assign rep_inc   = {1'b0, replace_q} + 7'd1;

	// Gallery memory
	always_ff @(posedge clk) begin
		if (gal_we) begin
			gal_mem[gal_wa] <= wr_data;
		end
		gal_rd_s1 <= gal_mem[gal_ra];
	end

	// Query buffer
	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[pos_q[fgcm_pkg::IDX_W-1:0]] <= wr_data;
		end
		q_rd_s1 <= q_mem[mac_i_q[fgcm_pkg::IDX_W-1:0]];
	end

	// Square-norm memory
	always_ff @(posedge clk) begin
		if (cmd.store_fin) begin
			norm_mem[target_q] <= sqsum_q;
		end
		if (cmd.norm_rd) begin
			norm_rd_q <= norm_mem[e_q[fgcm_pkg::SLOT_W-1:0]];
		end
	end

	// Root and divide units
	assign sqrt_start = cmd.q_start || cmd.entry_start;
	assign sqrt_rad   = cmd.q_start ? sqsum_q : norm_rd_q;

	fgcm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_rad),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	assign acc_abs  = acc_q[fgcm_pkg::DOT_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign ssum_abs = ssum_q[fgcm_pkg::SSUM_W-1] ? (~ssum_q + 1'b1) : ssum_q;

	assign div_start = cmd.div_cos || cmd.avg_start;
	assign div_num   = cmd.div_cos ? {mag_q, {fgcm_pkg::FRAC_W{1'b0}}}
		: {{(fgcm_pkg::NUM_W-fgcm_pkg::SSUM_W){1'b0}}, ssum_abs};
	assign div_den   = cmd.div_cos ? den_q
		: {{(fgcm_pkg::NORM_W-fgcm_pkg::CNT_W){1'b0}}, count_q};

	fgcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// Signed, saturated similarity of the current entry
	always_comb begin
		if (den_zero_q) begin
			sim_val = '0;
		end else if (!neg_q) begin
			sim_val = (div_ovf || div_quo > 22'd32767) ? 16'sh7FFF
				: $signed(div_quo[fgcm_pkg::SIM_W-1:0]);
		end else begin
			sim_val = (div_ovf || div_quo > 22'd32768) ? 16'sh8000
				: $signed(~div_quo[fgcm_pkg::SIM_W-1:0] + 1'b1);
		end
	end

	// Mean: truncated toward zero, zero for an empty gallery
	always_comb begin
		if (count_q == '0) begin
			avg_val = '0;
		end else if (ssum_q[fgcm_pkg::SSUM_W-1]) begin
			avg_val = ~div_quo[fgcm_pkg::SIM_W-1:0] + 1'b1;
		end else begin
			avg_val = div_quo[fgcm_pkg::SIM_W-1:0];
		end
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q       <= fgcm_pkg::FLEN_RESET;
			limit_q      <= fgcm_pkg::LIMIT_RESET;
			replace_q    <= fgcm_pkg::LIMIT_RESET[fgcm_pkg::LIMIT_W-1:1];
			target_q     <= '0;
			count_q      <= '0;
			pos_q        <= '0;
			sqsum_q      <= '0;
			close_func_q <= fgcm_pkg::FUNC_STORE;
			e_q          <= '0;
			mac_run_q    <= 1'b0;
			mac_i_q      <= '0;
			rd_v_s1      <= 1'b0;
			prod_v_s2    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Register writes
			if (cfg_write && cfg_index == fgcm_pkg::REG_FLEN) begin
				flen_q <= cfg_flen;
			end
			if (cfg_write && cfg_index == fgcm_pkg::REG_LIMIT) begin
				limit_q   <= cfg_lim;
				replace_q <= cfg_lim[fgcm_pkg::LIMIT_W-1:1];
			end

			// Accepted item
			if (cmd.take && func == fgcm_pkg::FUNC_CLEAR) begin
				count_q <= '0;
				pos_q   <= '0;
				sqsum_q <= '0;
			end
			if (elem_live) begin
				close_func_q <= func;
				target_q     <= tslot;
				if (in_range) begin
					sqsum_q <= sqsum_q +
						{{(fgcm_pkg::NORM_W-fgcm_pkg::SQ_W){1'b0}}, elem_sq};
					pos_q   <= pos_q + 1'b1;
				end
			end

			// Zero padding sweep
			if (cmd.pad && in_range) begin
				pos_q <= pos_q + 1'b1;
			end

			// Close a stored vector
			if (cmd.store_fin) begin
				pos_q   <= '0;
				sqsum_q <= '0;
				if ({1'b0, count_q} < {1'b0, limit_q}) begin
					count_q <= count_q + 1'b1;
				end else if (rep_inc >= limit_q) begin
					replace_q <= limit_q[fgcm_pkg::LIMIT_W-1:1];
				end else begin
					replace_q <= rep_inc[fgcm_pkg::SLOT_W-1:0];
				end
			end

			// Start of a search
			if (cmd.q_start) begin
				pos_q   <= '0;
				sqsum_q <= '0;
				e_q     <= '0;
			end
			if (cmd.sim) begin
				e_q <= e_q + 1'b1;
			end

			// MAC address sequencer
			if (cmd.entry_start) begin
				mac_run_q <= 1'b1;
				mac_i_q   <= '0;
			end else if (mac_run_q) begin
				mac_i_q <= mac_i_q + 1'b1;
				if (mac_i_q == flen_q - 1'b1) begin
					mac_run_q <= 1'b0;
				end
			end
			rd_v_s1   <= mac_run_q;
			prod_v_s2 <= rd_v_s1;

			// Output register handshake
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Arithmetic and result payload
	always_ff @(posedge clk) begin
		prod_s2 <= gal_rd_s1 * q_rd_s1;
		if (cmd.entry_start) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + {{(fgcm_pkg::DOT_W-fgcm_pkg::SQ_W){prod_s2[fgcm_pkg::SQ_W-1]}},
				prod_s2};
		end
		if (cmd.rq_latch) begin
			rq_q <= sqrt_root;
		end
		if (cmd.mul) begin
			den_q      <= rq_q * sqrt_root;
			den_zero_q <= (rq_q == '0) || (sqrt_root == '0);
			mag_q      <= acc_abs[fgcm_pkg::MAG_W-1:0];
			neg_q      <= acc_q[fgcm_pkg::DOT_W-1];
		end
		if (cmd.q_start) begin
			ssum_q <= '0;
			max_q  <= '0;
		end else if (cmd.sim) begin
			ssum_q <= ssum_q + {{(fgcm_pkg::SSUM_W-fgcm_pkg::SIM_W){sim_val[fgcm_pkg::SIM_W-1]}},
				sim_val};
			if (!sim_val[fgcm_pkg::SIM_W-1] && sim_val[fgcm_pkg::MAXS_W-1:0] > max_q) begin
				max_q <= sim_val[fgcm_pkg::MAXS_W-1:0];
			end
		end

		// Result fields per kind
		if (cmd.take && func == fgcm_pkg::FUNC_CLEAR) begin
			res_kind_q <= fgcm_pkg::KIND_CLEAR;
			res_max_q  <= '0;
			res_avg_q  <= '0;
			res_slot_q <= '0;
		end else if (cmd.store_fin) begin
			res_kind_q <= fgcm_pkg::KIND_STORE;
			res_max_q  <= '0;
			res_avg_q  <= '0;
			res_slot_q <= target_q;
		end else if (cmd.avg_fin) begin
			res_kind_q <= fgcm_pkg::KIND_QUERY;
			res_max_q  <= max_q;
			res_avg_q  <= avg_val;
			res_slot_q <= '0;
		end

		if (cmd.emit) begin
			out_kind_q  <= res_kind_q;
			out_max_q   <= res_max_q;
			out_avg_q   <= res_avg_q;
			out_slot_q  <= res_slot_q;
			out_count_q <= count_q;
			out_full_q  <= ({1'b0, count_q} >= {1'b0, limit_q});
		end
	end

	// Status to the controller
	always_comb begin
		sts              = '0;
		sts.pad_done     = !in_range;
		sts.close_store  = (close_func_q == fgcm_pkg::FUNC_STORE);
		sts.sqrt_busy    = sqrt_busy;
		sts.mac_busy     = mac_run_q || rd_v_s1 || prod_v_s2;
		sts.div_busy     = div_busy;
		sts.den_zero     = den_zero_q;
		sts.entries_left = (e_q < count_q);
		sts.count_zero   = (count_q == '0);
		sts.out_free     = !out_valid_q || !out_stall;
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign max_similarity = out_max_q;
	assign avg_similarity = $signed(out_avg_q);
	assign entry_count    = out_count_q;
	assign gallery_full   = out_full_q;
	assign written_slot   = out_slot_q;

endmodule

FILE: design/feature_gallery_cosine_match.sv
// Top level of the feature gallery cosine matcher: controller plus datapath.
// Depends on fgcm_pkg, fgcm_ctrl and fgcm_datapath.
//
// Usage
// - Input channel (in_valid/in_stall): one vector element per item. func
//   selects store, query or gallery clear; last_element closes a vector.
// - Output channel (out_valid/out_stall): one item per closed vector and
//   per clear. A registered output stage holds a result while out_stall is
//   high; the block keeps working and waits only when it has a second
//   result ready for a still-occupied output register.
// - Register port (cfg_write/cfg_index/cfg_data): write only while idle.
// Sequence
// - Elements that do not close a vector are taken without a stall.
// - Closing a vector first fills the rest of it with zeros, one element a
//   cycle, up to feature_length. A store then writes the square norm.
// - A query first takes the query root, then per held entry runs one MAC per
//   cycle on the gallery memory read port alongside the entry root, then a
//   multiply and a 22-step divide, and last divides for the mean.
// - A clear goes straight to emitting its result.
// Reset clears the entry count and vector position; memories need no
// clearing pass. in_stall is high whenever an item is in progress.
module feature_gallery_cosine_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [fgcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fgcm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic signed [fgcm_pkg::ELEM_W-1:0]  element_value,
	input  logic                                last_element,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          result_kind,
	output logic [fgcm_pkg::MAXS_W-1:0]         max_similarity,
	output logic signed [fgcm_pkg::SIM_W-1:0]   avg_similarity,
	output logic [fgcm_pkg::CNT_W-1:0]          entry_count,
	output logic                                gallery_full,
	output logic [fgcm_pkg::SLOT_W-1:0]         written_slot
);

	fgcm_pkg::cmd_t cmd;
	fgcm_pkg::sts_t sts;

	fgcm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.func         (func),
		.last_element (last_element),
		.sts          (sts),
		.in_stall     (in_stall),
		.cmd          (cmd)
	);

	fgcm_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.element_value  (element_value),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.max_similarity (max_similarity),
		.avg_similarity (avg_similarity),
		.entry_count    (entry_count),
		.gallery_full   (gallery_full),
		.written_slot   (written_slot)
	);

endmodule

FILE: design/fgcm_checker.sv
// Port-level checks for the feature gallery cosine matcher, bound to the
// top level. Depends on fgcm_pkg.
module fgcm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [1:0]                          func,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [1:0]                          result_kind,
	input logic [fgcm_pkg::MAXS_W-1:0]         max_similarity,
	input logic signed [fgcm_pkg::SIM_W-1:0]   avg_similarity,
	input logic [fgcm_pkg::CNT_W-1:0]          entry_count,
	input logic                                gallery_full
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind))
		else $error("stalled result dropped or changed");

	// Store and clear items carry no similarity figures
	a_no_sim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != fgcm_pkg::KIND_QUERY |->
		max_similarity == '0 && avg_similarity == '0)
		else $error("similarity on a non-query item");

	// A clear leaves an empty gallery
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == fgcm_pkg::KIND_CLEAR |->
		entry_count == '0 && !gallery_full)
		else $error("clear result shows entries");

	// A taken clear raises in_stall
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == fgcm_pkg::FUNC_CLEAR |=> in_stall)
		else $error("input taken right after clear");

endmodule

bind feature_gallery_cosine_match fgcm_checker u_fgcm_checker (.*);
